>>> rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants of the insertion sorter
// Defines the default depth, the value type, the controller states and the
// command that the controller sends to every cell of the chain.
// ----------------------------------------------------------------------------
package isc_pkg;

   localparam int ISC_DEPTH   = 16;
   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_DRAIN
   } state_type;

   // Command broadcast from the controller to all cells.
   typedef struct packed {
      logic      insert;
      logic      drain;
      logic      descending;
      value_type value;
   } cell_cmd_type;

endpackage

>>> rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter: streaming insertion sort over a chain of cells
// Inserts one signed value per item into a sorted chain and drains the
// sorted set after the item that ends the set.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one value per item; req_end_of_set marks the last
// item of a set. While a set is being filled, one item is taken every cycle:
// the new value is compared in every cell at once and the chain shifts in the
// same cycle. Items that arrive while all DEPTH cells are occupied are
// dropped, and every result of that set then shows rsp_dropped.
// After the end-of-set item, req_ready goes low and the chain shifts out one
// element per cycle from its head into the rsp output register. The first
// result enters the output register after the state has turned to drain;
// the chain keeps shifting while rsp_ready stays high, and rsp_last_out
// marks its final element. A stalled receiver holds the output register and
// freezes the chain. Once the final element sits in the output register, the
// next set is accepted even while that result still waits. The csr channel
// writes the order bit (0 ascending, 1 descending); it is always ready. The
// user must write it only while the block is idle, not checked by the block.
// Reset empties the chain, clears the overflow flag and selects ascending.
// ----------------------------------------------------------------------------
module insertion_sorter
   import isc_pkg::*;
#(
   parameter int DEPTH = ISC_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_value,
   input  logic        req_end_of_set,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_sorted_value,
   output logic        rsp_last_out,
   output logic        rsp_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_descending
);

   state_type    state_ff;
   state_type    state_in;
   logic         descending_ff;
   logic         overflow_ff;
   logic         overflow_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   value_type    rsp_value_ff;
   logic         rsp_last_ff;
   logic         rsp_dropped_ff;

   logic         req_take;
   logic         full;
   logic         load;
   logic         last_load;
   cell_cmd_type cmd;

   value_type        cell_value [DEPTH];
   logic [DEPTH-1:0] cell_occ;
   logic [DEPTH-1:0] cell_stay;

   assign full      = cell_occ[DEPTH-1];
   assign req_take  = req_valid && req_ready;
   assign last_load = load && !cell_occ[1];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_take && req_end_of_set) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (last_load) begin
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready      = 1'b0;
      load           = 1'b0;
      cmd.insert     = 1'b0;
      cmd.drain      = 1'b0;
      cmd.descending = descending_ff;
      cmd.value      = req_value;
      unique case (state_ff)
         ST_FILL: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid && !full;
         end
         ST_DRAIN: begin
            load      = !rsp_valid_ff || rsp_ready;
            cmd.drain = load;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      overflow_in = overflow_ff;
      if (req_take && full) begin
         overflow_in = 1'b1;
      end else if (last_load) begin
         overflow_in = 1'b0;
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         descending_ff <= 1'b0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            descending_ff <= csr_descending;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff   <= cell_value[0];
         rsp_last_ff    <= !cell_occ[1];
         rsp_dropped_ff <= overflow_ff;
      end
   end

   // The head cell sees a virtual left neighbor that stays ahead, so it takes
   // the new value when its own element does not stay.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_value;
      logic      left_occ;
      logic      left_stay;
      value_type right_value;
      logic      right_occ;

      if (i == 0) begin : g_head
         assign left_value = cmd.value;
         assign left_occ   = 1'b1;
         assign left_stay  = 1'b1;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_occ   = cell_occ[i-1];
         assign left_stay  = cell_stay[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = '0;
         assign right_occ   = 1'b0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_occ   = cell_occ[i+1];
      end

      isc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_value  (left_value),
         .left_occ    (left_occ),
         .left_stay   (left_stay),
         .right_value (right_value),
         .right_occ   (right_occ),
         .value       (cell_value[i]),
         .occ         (cell_occ[i]),
         .stay        (cell_stay[i])
      );
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_dropped      = rsp_dropped_ff;

endmodule

>>> rtl/isc_cell.sv
// ----------------------------------------------------------------------------
// isc_cell: one compare-and-shift cell of the sorting chain
// Holds one element and its occupied bit. On insert it keeps its element,
// takes the new value, or takes its left neighbor's element; on drain it
// takes its right neighbor's element.
// ----------------------------------------------------------------------------
module isc_cell
   import isc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  value_type    left_value,
   input  logic         left_occ,
   input  logic         left_stay,
   input  value_type    right_value,
   input  logic         right_occ,
   output value_type    value,
   output logic         occ,
   output logic         stay
);

   value_type value_ff;
   value_type value_in;
   logic      occ_ff;
   logic      occ_in;

   // The element stays ahead of the new value if it sorts strictly before it.
   always_comb begin
      if (cmd.descending) begin
         stay = occ_ff && (cmd.value < value_ff);
      end else begin
         stay = occ_ff && (value_ff < cmd.value);
      end
   end

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (cmd.insert) begin
         if (!stay) begin
            value_in = left_stay ? cmd.value : left_value;
         end
         occ_in = occ_ff | left_occ;
      end else if (cmd.drain) begin
         value_in = right_value;
         occ_in   = right_occ;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign value = value_ff;
   assign occ   = occ_ff;

endmodule

>>> rtl/isc_checker.sv
// ----------------------------------------------------------------------------
// isc_checker: port-level checks of the insertion sorter
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module isc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_end_of_set,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_last_out,
   input logic        rsp_dropped
);

   // A stalled result item stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item withdrawn while stalled");

   // While a set drains, no new item is taken before its final element.
   a_no_req_mid_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |-> !req_ready)
      else $error("input taken while a set is still draining");

   // The item that ends a set starts the drain.
   a_eos_drain: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_set |=> !req_ready)
      else $error("input still ready after end of set");

   // The dropped flag is the same on every result of one set.
   a_dropped_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_out |=>
         !rsp_valid || (rsp_dropped == $past(rsp_dropped)))
      else $error("dropped flag changed within a set");

endmodule

bind insertion_sorter isc_checker u_isc_checker (.*);
